@@ hdl/acf_pkg.sv @@
// ----------------------------------------------------------------------------
// acf_pkg
// shared types, codes and constants of the alarm count filter
// ----------------------------------------------------------------------------
package acf_pkg;

  // clamp limits for passed alarms
  localparam int unsigned SEVERITY_LEVELS = 4;
  localparam int unsigned STATUS_CODES    = 22;

  localparam int unsigned STATUS_W   = 6;
  localparam int unsigned SEVERITY_W = 4;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned WINDOW_W   = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [SEVERITY_W-1:0] SEVERITY_TOP = SEVERITY_W'(SEVERITY_LEVELS - 1);
  localparam logic [STATUS_W-1:0]   STATUS_TOP   = STATUS_W'(STATUS_CODES - 1);
  localparam logic [COUNT_W-1:0]    COUNT_MAX    = '1;

  // request kinds
  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0]  required_count;
    logic [WINDOW_W-1:0] window_seconds;
  } acf_cfg_t;

  typedef struct packed {
    logic                  req_type;
    logic [STATUS_W-1:0]   alarm_status;
    logic [SEVERITY_W-1:0] alarm_severity;
    logic [TIME_W-1:0]     now_seconds;
  } acf_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   seen_status;
    logic [SEVERITY_W-1:0] seen_severity;
    logic [TIME_W-1:0]     window_start;
    logic                  timer_running;
    logic [TIME_W-1:0]     timer_start;
    logic [COUNT_W-1:0]    change_count;
    logic [SEVERITY_W-1:0] committed_severity;
  } acf_state_t;

  typedef struct packed {
    logic                  pass;
    logic [STATUS_W-1:0]   pass_status;
    logic [SEVERITY_W-1:0] pass_severity;
    logic [TIME_W-1:0]     pass_time;
  } acf_result_t;

endpackage

@@ hdl/acf_step.sv @@
// ----------------------------------------------------------------------------
// acf_step
// next-state and result logic for one request of the alarm count filter
// ----------------------------------------------------------------------------
module acf_step (
  input  acf_pkg::acf_cfg_t    cfg_i,
  input  acf_pkg::acf_state_t  state_i,
  input  acf_pkg::acf_req_t    req_i,
  output acf_pkg::acf_state_t  state_o,
  output acf_pkg::acf_result_t result_o
);

  logic [acf_pkg::TIME_W-1:0]     timer_age;
  logic [acf_pkg::TIME_W-1:0]     window_age;
  logic [acf_pkg::TIME_W-1:0]     window_ext;
  logic [acf_pkg::SEVERITY_W-1:0] prev_sev;
  logic [acf_pkg::SEVERITY_W-1:0] cur_sev;
  logic [acf_pkg::COUNT_W-1:0]    count_inc;
  logic                           emit;
  logic [acf_pkg::STATUS_W-1:0]   emit_status;
  logic [acf_pkg::SEVERITY_W-1:0] emit_severity;
  logic [acf_pkg::TIME_W-1:0]     emit_time;
  logic [acf_pkg::STATUS_W-1:0]   clamp_status;
  logic [acf_pkg::SEVERITY_W-1:0] clamp_severity;
  logic                           counted;
  logic                           other_edge;

  assign timer_age  = req_i.now_seconds - state_i.timer_start;
  assign window_age = req_i.now_seconds - state_i.window_start;
  assign window_ext = {{(acf_pkg::TIME_W - acf_pkg::WINDOW_W){1'b0}}, cfg_i.window_seconds};
  assign prev_sev   = state_i.seen_severity;
  assign cur_sev    = state_i.committed_severity;
  assign count_inc  = (state_i.change_count == acf_pkg::COUNT_MAX) ?
                      state_i.change_count : state_i.change_count + 1'b1;
  assign counted    = ((cur_sev == '0) && (prev_sev == '0)) ||
                      ((cur_sev != '0) && (req_i.alarm_severity == '0));
  assign other_edge = ((cur_sev == '0) && (req_i.alarm_severity == '0)) ||
                      ((cur_sev != '0) && (prev_sev == '0));

  always_comb begin
    state_o       = state_i;
    emit          = 1'b0;
    emit_status   = req_i.alarm_status;
    emit_severity = req_i.alarm_severity;
    emit_time     = req_i.now_seconds;
    if (req_i.req_type == acf_pkg::REQ_TICK) begin
      // window timer expiry passes the latest seen pair
      if (state_i.timer_running && (timer_age >= window_ext)) begin
        emit                  = 1'b1;
        emit_status           = state_i.seen_status;
        emit_severity         = state_i.seen_severity;
        emit_time             = state_i.window_start;
        state_o.window_start  = '0;
        state_o.timer_running = 1'b0;
        state_o.change_count  = '0;
      end
    end else if ((req_i.alarm_status != state_i.seen_status) ||
                 (req_i.alarm_severity != state_i.seen_severity)) begin
      state_o.seen_status   = req_i.alarm_status;
      state_o.seen_severity = req_i.alarm_severity;
      if (counted) begin
        if ((state_i.window_start == '0) || (window_age > window_ext)) begin
          // open a new window, timer keeps its start if already running
          if (!state_i.timer_running) begin
            state_o.timer_running = 1'b1;
            state_o.timer_start   = req_i.now_seconds;
          end
          state_o.change_count = acf_pkg::COUNT_W'(1);
          state_o.window_start = req_i.now_seconds;
        end else if (count_inc >= cfg_i.required_count) begin
          emit                  = 1'b1;
          state_o.timer_running = 1'b0;
          state_o.change_count  = '0;
          state_o.window_start  = '0;
        end else begin
          state_o.change_count = count_inc;
        end
      end else if (other_edge) begin
        state_o.timer_running = 1'b0;
        emit                  = (cur_sev != '0);
      end else begin
        emit = (cur_sev != '0);
      end
    end
    clamp_severity = (emit_severity > acf_pkg::SEVERITY_TOP) ? acf_pkg::SEVERITY_TOP
                                                            : emit_severity;
    clamp_status   = (emit_status > acf_pkg::STATUS_TOP) ? acf_pkg::STATUS_TOP
                                                        : emit_status;
    if (emit) begin
      state_o.committed_severity = clamp_severity;
    end
    result_o.pass          = emit;
    result_o.pass_status   = clamp_status;
    result_o.pass_severity = clamp_severity;
    result_o.pass_time     = emit_time;
  end

endmodule

@@ hdl/alarm_count_filter_core.sv @@
// ----------------------------------------------------------------------------
// alarm_count_filter_core
// count filter for one alarm channel: events and timer ticks in, passed alarms out
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------------
//  request  | in        | in_valid_i / in_stall_o | req_type, alarm_status/severity,
//           |           |                         | now_seconds
//  result   | out       | out_valid_o/out_stall_i | pass_status, pass_severity, pass_time
//  config   | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
//  one request per cycle sustained while the result side is not stalled; a taken request
//  is held in the request register, then a passed result in the result register
//  the filter state is updated in the cycle the request leaves the request register
//  reset clears the filter state, valid flags and loads both config regs with one
//  a stalled result holds the request register; the request input only stalls
//  while the request register is full and cannot move on
// ----------------------------------------------------------------------------
module alarm_count_filter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic [acf_pkg::STATUS_W-1:0]        alarm_status_i,
  input  logic [acf_pkg::SEVERITY_W-1:0]      alarm_severity_i,
  input  logic [acf_pkg::TIME_W-1:0]          now_seconds_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [acf_pkg::STATUS_W-1:0]        pass_status_o,
  output logic [acf_pkg::SEVERITY_W-1:0]      pass_severity_o,
  output logic [acf_pkg::TIME_W-1:0]          pass_time_o,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [acf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [acf_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  // configuration registers
  acf_pkg::acf_cfg_t    cfg_q;

  // request register
  logic                 in_valid_q;
  acf_pkg::acf_req_t    req_q;

  // filter state
  acf_pkg::acf_state_t  state_q;
  acf_pkg::acf_state_t  state_d;

  // result register
  logic                 out_valid_q;
  acf_pkg::acf_result_t step_result;
  logic [acf_pkg::STATUS_W-1:0]   out_status_q;
  logic [acf_pkg::SEVERITY_W-1:0] out_severity_q;
  logic [acf_pkg::TIME_W-1:0]     out_time_q;

  logic out_free;
  logic advance;
  logic in_take;

  // result slot can take a new result when empty or draining this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  // request in the register is processed when the result slot is free
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.required_count <= acf_pkg::COUNT_W'(1);
      cfg_q.window_seconds <= acf_pkg::WINDOW_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        acf_pkg::CFG_REQUIRED_COUNT: cfg_q.required_count <= cfg_data_i[acf_pkg::COUNT_W-1:0];
        acf_pkg::CFG_WINDOW_SECONDS: cfg_q.window_seconds <= cfg_data_i[acf_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // request register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take || advance) begin
      in_valid_q <= in_take;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q.req_type       <= req_type_i;
      req_q.alarm_status   <= alarm_status_i;
      req_q.alarm_severity <= alarm_severity_i;
      req_q.now_seconds    <= now_seconds_i;
    end
  end

  // single pass of filter logic on the registered request
  acf_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .req_i    (req_q),
    .state_o  (state_d),
    .result_o (step_result)
  );

  // filter state commits only when the request moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result valid flag: loads on a pass, clears when taken downstream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && step_result.pass;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance && step_result.pass) begin
      out_status_q   <= step_result.pass_status;
      out_severity_q <= step_result.pass_severity;
      out_time_q     <= step_result.pass_time;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pass_status_o   = out_status_q;
  assign pass_severity_o = out_severity_q;
  assign pass_time_o     = out_time_q;

  // committed severity always lies inside the clamp range
  a_committed_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.committed_severity <= acf_pkg::SEVERITY_TOP)
    else $error("committed severity above top level");

  // a passed result carries clamped fields
  a_result_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_severity_q <= acf_pkg::SEVERITY_TOP) &&
                     (out_status_q <= acf_pkg::STATUS_TOP)))
    else $error("result fields outside clamp range");

  // request input only stalls while a request is held
  a_stall_holds_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("request stall without a held request");

  // a new result appears only after a request was processed
  a_result_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("result without a processed request");

  // state stays put while no request is processed
  a_state_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(advance) |-> $stable(state_q))
    else $error("filter state changed without a request");

endmodule

@@ tb/acf_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// acf_checker
// predicts the passed alarms of the count filter from accepted requests and
// compares them, field by field and in order, with the result channel
// ----------------------------------------------------------------------------
module acf_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           req_type_i,
  input  logic [acf_pkg::STATUS_W-1:0]   alarm_status_i,
  input  logic [acf_pkg::SEVERITY_W-1:0] alarm_severity_i,
  input  logic [acf_pkg::TIME_W-1:0]     now_seconds_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [acf_pkg::STATUS_W-1:0]   pass_status_i,
  input  logic [acf_pkg::SEVERITY_W-1:0] pass_severity_i,
  input  logic [acf_pkg::TIME_W-1:0]     pass_time_i,
  input  logic                           cfg_we_i,
  input  logic [acf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [acf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    checked_o
);

  typedef struct packed {
    logic [acf_pkg::STATUS_W-1:0]   status;
    logic [acf_pkg::SEVERITY_W-1:0] severity;
    logic [acf_pkg::TIME_W-1:0]     stamp;
  } alarm_out_t;

  typedef struct packed {
    logic [acf_pkg::STATUS_W-1:0]   last_status;
    logic [acf_pkg::SEVERITY_W-1:0] last_severity;
    logic [acf_pkg::TIME_W-1:0]     win_open;
    logic                           timer_on;
    logic [acf_pkg::TIME_W-1:0]     timer_t0;
    logic [acf_pkg::COUNT_W-1:0]    changes;
    logic [acf_pkg::SEVERITY_W-1:0] committed;
  } filter_state_t;

  filter_state_t                flt;
  logic [acf_pkg::COUNT_W-1:0]  need_changes;
  logic [acf_pkg::WINDOW_W-1:0] win_len;
  alarm_out_t                   expected_alarms[$];
  alarm_out_t                   want;
  int unsigned                  mismatches;
  int unsigned                  compared;

  // clamp and queue one passed alarm, it becomes the committed severity
  function automatic void pass_alarm(input logic [acf_pkg::STATUS_W-1:0] st,
                                     input logic [acf_pkg::SEVERITY_W-1:0] sv,
                                     input logic [acf_pkg::TIME_W-1:0] stamp);
    alarm_out_t a;
    a.status   = (st >= acf_pkg::STATUS_CODES) ? acf_pkg::STATUS_TOP : st;
    a.severity = (sv >= acf_pkg::SEVERITY_LEVELS) ? acf_pkg::SEVERITY_TOP : sv;
    a.stamp    = stamp;
    flt.committed = a.severity;
    expected_alarms.push_back(a);
  endfunction

  function automatic void filter_request(input logic kind,
                                         input logic [acf_pkg::STATUS_W-1:0] st,
                                         input logic [acf_pkg::SEVERITY_W-1:0] sv,
                                         input logic [acf_pkg::TIME_W-1:0] now);
    logic [acf_pkg::SEVERITY_W-1:0] prev;
    logic [acf_pkg::SEVERITY_W-1:0] cur;
    logic [acf_pkg::TIME_W-1:0]     elapsed;
    logic [acf_pkg::TIME_W-1:0]     stamp;
    if (kind == acf_pkg::REQ_TICK) begin
      elapsed = now - flt.timer_t0;
      if (!flt.timer_on || elapsed < acf_pkg::TIME_W'(win_len)) return;
      stamp        = flt.win_open;
      flt.win_open = '0;
      flt.timer_on = 1'b0;
      flt.changes  = '0;
      pass_alarm(flt.last_status, flt.last_severity, stamp);
      return;
    end
    // repeated pair is dropped
    if (st == flt.last_status && sv == flt.last_severity) return;
    prev = flt.last_severity;
    flt.last_status   = st;
    flt.last_severity = sv;
    cur = flt.committed;
    // into or out of alarm: counted inside the window
    if ((cur == '0 && prev == '0) || (cur != '0 && sv == '0)) begin
      elapsed = now - flt.win_open;
      if (flt.win_open == '0 || elapsed > acf_pkg::TIME_W'(win_len)) begin
        if (!flt.timer_on) begin
          flt.timer_on = 1'b1;
          flt.timer_t0 = now;
        end
        flt.changes  = acf_pkg::COUNT_W'(1);
        flt.win_open = now;
        return;
      end
      if (flt.changes != acf_pkg::COUNT_MAX) flt.changes = flt.changes + 1'b1;
      if (flt.changes >= need_changes) begin
        flt.timer_on = 1'b0;
        flt.changes  = '0;
        flt.win_open = '0;
        pass_alarm(st, sv, now);
      end
      return;
    end
    if ((cur == '0 && sv == '0) || (cur != '0 && prev == '0)) begin
      flt.timer_on = 1'b0;
      if (cur != '0) pass_alarm(st, sv, now);
      return;
    end
    if (cur != '0) pass_alarm(st, sv, now);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flt          = '0;
      need_changes = acf_pkg::COUNT_W'(1);
      win_len      = acf_pkg::WINDOW_W'(1);
      expected_alarms.delete();
      mismatches   = 0;
      compared     = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == acf_pkg::CFG_REQUIRED_COUNT) begin
          need_changes = cfg_data_i[acf_pkg::COUNT_W-1:0];
        end else if (cfg_index_i == acf_pkg::CFG_WINDOW_SECONDS) begin
          win_len = cfg_data_i[acf_pkg::WINDOW_W-1:0];
        end
      end
      // result first: it can never belong to the request taken at this edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_alarms.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected alarm, expected none, got status %0d severity %0d time %0d",
                   $time, pass_status_i, pass_severity_i, pass_time_i);
        end else begin
          want = expected_alarms.pop_front();
          compared++;
          if (pass_status_i !== want.status) begin
            mismatches++;
            $display("%0t: pass_status expected %0d, got %0d",
                     $time, want.status, pass_status_i);
          end
          if (pass_severity_i !== want.severity) begin
            mismatches++;
            $display("%0t: pass_severity expected %0d, got %0d",
                     $time, want.severity, pass_severity_i);
          end
          if (pass_time_i !== want.stamp) begin
            mismatches++;
            $display("%0t: pass_time expected %0d, got %0d",
                     $time, want.stamp, pass_time_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        filter_request(req_type_i, alarm_status_i, alarm_severity_i, now_seconds_i);
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_alarms.size();
    checked_o    <= compared;
  end

endmodule

@@ tb/tb_alarm_count_filter_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_alarm_count_filter_core
// drives alarm events and timer ticks into the count filter under random
// request gaps and result stalls, across several register settings; the
// checker beside the block predicts and compares every passed alarm
// ----------------------------------------------------------------------------
module tb_alarm_count_filter_core;

  localparam int unsigned CYCLE_LIMIT    = 300000;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned ITEMS_PER_PHASE = 175;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // request channel
  logic                           in_valid       = 1'b0;
  logic                           in_stall;
  logic                           req_type       = acf_pkg::REQ_EVENT;
  logic [acf_pkg::STATUS_W-1:0]   alarm_status   = '0;
  logic [acf_pkg::SEVERITY_W-1:0] alarm_severity = '0;
  logic [acf_pkg::TIME_W-1:0]     now_seconds    = '0;

  // result channel
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [acf_pkg::STATUS_W-1:0]   pass_status;
  logic [acf_pkg::SEVERITY_W-1:0] pass_severity;
  logic [acf_pkg::TIME_W-1:0]     pass_time;

  // register writes
  logic                           cfg_we    = 1'b0;
  logic [acf_pkg::CFG_IDX_W-1:0]  cfg_index = acf_pkg::CFG_REQUIRED_COUNT;
  logic [acf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // checker feedback
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  // stimulus bookkeeping
  int unsigned     cycle_cnt  = 0;
  int unsigned     sent_reqs  = 0;
  int unsigned     sent_ticks = 0;
  int unsigned     settings   = 0;
  bit              quiet_in   = 1'b0;
  bit              quiet_out  = 1'b0;
  int unsigned     stall_left = 0;
  int unsigned     stall_draw;
  logic [acf_pkg::TIME_W-1:0] t_now = acf_pkg::TIME_W'(100);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  alarm_count_filter_core u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .req_type_i       (req_type),
    .alarm_status_i   (alarm_status),
    .alarm_severity_i (alarm_severity),
    .now_seconds_i    (now_seconds),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .pass_status_o    (pass_status),
    .pass_severity_o  (pass_severity),
    .pass_time_o      (pass_time),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  acf_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .req_type_i       (req_type),
    .alarm_status_i   (alarm_status),
    .alarm_severity_i (alarm_severity),
    .now_seconds_i    (now_seconds),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .pass_status_i    (pass_status),
    .pass_severity_i  (pass_severity),
    .pass_time_i      (pass_time),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  // watchdog, sized well above the slowest legal run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d alarms still expected", cycle_cnt, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: after each taken alarm, draw a random stall length and hold out_stall for it
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      stall_draw = quiet_out ? 0 : $urandom_range(0, 7);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // one request: optional gap with valid low, then hold until taken
  // valid stays high on return so back-to-back requests need no extra edge
  task automatic send_req(input logic kind, input logic [acf_pkg::STATUS_W-1:0] st,
                          input logic [acf_pkg::SEVERITY_W-1:0] sv,
                          input logic [acf_pkg::TIME_W-1:0] now);
    int unsigned gap;
    gap = quiet_in ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    req_type       <= kind;
    alarm_status   <= st;
    alarm_severity <= sv;
    now_seconds    <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_reqs++;
    if (kind == acf_pkg::REQ_TICK) sent_ticks++;
  endtask

  // stop sending and let every expected alarm drain, then settle
  task automatic wait_idle(input int unsigned settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // both registers, written back to back while the block is idle
  task automatic write_settings(input logic [acf_pkg::COUNT_W-1:0] need,
                                input logic [acf_pkg::WINDOW_W-1:0] win);
    cfg_we    <= 1'b1;
    cfg_index <= acf_pkg::CFG_REQUIRED_COUNT;
    cfg_data  <= acf_pkg::CFG_DATA_W'(need);
    @(posedge clk);
    cfg_index <= acf_pkg::CFG_WINDOW_SECONDS;
    cfg_data  <= win;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // random event or tick; time mostly creeps forward, sometimes jumps,
  // runs backwards or lands on zero; statuses come from small pools so
  // pairs repeat and severities swing in and out of alarm
  task automatic random_request(input logic [acf_pkg::WINDOW_W-1:0] win);
    logic                           kind;
    logic [acf_pkg::STATUS_W-1:0]   st;
    logic [acf_pkg::SEVERITY_W-1:0] sv;
    int unsigned                    r;
    r = $urandom_range(0, 99);
    if (r < 75) t_now = t_now + $urandom_range(0, 2);
    else if (r < 90) t_now = t_now + $urandom_range(0, 2 * win + 2);
    else if (r < 95) t_now = t_now - $urandom_range(1, 3);
    else if (r < 98) t_now = $urandom;
    else t_now = '0;
    kind = ($urandom_range(0, 3) == 0) ? acf_pkg::REQ_TICK : acf_pkg::REQ_EVENT;
    r = $urandom_range(0, 9);
    if (r < 7) st = acf_pkg::STATUS_W'($urandom_range(0, 3));
    else if (r < 9) st = acf_pkg::STATUS_W'($urandom_range(18, 25));
    else st = acf_pkg::STATUS_W'($urandom_range(0, 63));
    r = $urandom_range(0, 19);
    if (r < 9) sv = '0;
    else if (r < 16) sv = acf_pkg::SEVERITY_W'($urandom_range(1, 3));
    else sv = acf_pkg::SEVERITY_W'($urandom_range(4, 15));
    send_req(kind, st, sv, t_now);
  endtask

  initial begin
    logic [acf_pkg::COUNT_W-1:0]  need;
    logic [acf_pkg::WINDOW_W-1:0] win;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset settings: one change needed, one second window
    send_req(acf_pkg::REQ_EVENT, 6'd5,  4'd0,  32'd100);        // opens a window, starts timer
    send_req(acf_pkg::REQ_EVENT, 6'd5,  4'd0,  32'd100);        // same pair again, dropped
    send_req(acf_pkg::REQ_EVENT, 6'd63, 4'd15, 32'd101);        // second change passes, clamped
    send_req(acf_pkg::REQ_EVENT, 6'd63, 4'd7,  32'd102);        // change in alarm passes at once
    send_req(acf_pkg::REQ_EVENT, 6'd0,  4'd0,  32'd103);        // leaving alarm opens a window
    send_req(acf_pkg::REQ_TICK,  6'd63, 4'd15, 32'd103);        // timer not yet expired
    send_req(acf_pkg::REQ_TICK,  6'd0,  4'd0,  32'hFFFF_FFFF);  // expiry, window start stamp
    send_req(acf_pkg::REQ_EVENT, 6'd3,  4'd2,  32'd0);          // window opened at time zero
    send_req(acf_pkg::REQ_EVENT, 6'd3,  4'd1,  32'd1);          // change while not committed
    send_req(acf_pkg::REQ_EVENT, 6'd3,  4'd0,  32'd1);          // back to no alarm, timer stops
    send_req(acf_pkg::REQ_TICK,  6'd10, 4'd9,  32'd50);         // no timer running
    send_req(acf_pkg::REQ_EVENT, 6'd63, 4'd0,  32'hFFFF_FFFF);  // window at the top of time
    send_req(acf_pkg::REQ_EVENT, 6'd62, 4'd8,  32'd0);          // time wraps, inside window
    send_req(acf_pkg::REQ_EVENT, 6'd40, 4'd0,  32'd2);          // out of alarm opens a window
    send_req(acf_pkg::REQ_TICK,  6'd1,  4'd1,  32'd3);          // one window later: expiry
    send_req(acf_pkg::REQ_TICK,  6'd0,  4'd0,  32'd4);          // timer already stopped
    send_req(acf_pkg::REQ_EVENT, 6'd21, 4'd3,  32'd4);          // into alarm opens a window
    send_req(acf_pkg::REQ_EVENT, 6'd22, 4'd4,  32'd5);          // change not committed, no pass
    wait_idle(6);

    // random phases, extremes of both registers first
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin need = '0;                  win = '0;          end
        1: begin need = acf_pkg::COUNT_MAX;  win = '1;          end
        2: begin need = 8'd2;                win = 16'd5;       end
        3: begin need = 8'd1;                win = 16'd1;       end
        4: begin need = 8'd3;                win = 16'd20;      end
        5: begin
          need = acf_pkg::COUNT_W'($urandom_range(0, 6));
          win  = acf_pkg::WINDOW_W'($urandom_range(0, 12));
        end
        6: begin
          need = acf_pkg::COUNT_W'($urandom_range(0, 255));
          win  = acf_pkg::WINDOW_W'($urandom_range(0, 65535));
        end
        default: begin need = 8'd1;          win = 16'd2;       end
      endcase
      write_settings(need, win);
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        // stretches with no gaps or no stalls now and then
        if (n % 50 == 0) begin
          quiet_in  = ($urandom_range(0, 3) == 0);
          quiet_out <= ($urandom_range(0, 3) == 0);
        end
        // sender holds off until the result side has caught up
        if ($urandom_range(0, 99) == 0) wait_idle(0);
        random_request(win);
      end
      wait_idle(6);
    end

    wait_idle(8);
    $display("run covered %0d requests (%0d timer ticks) over %0d register settings",
             sent_reqs, sent_ticks, settings + 1);
    $display("%0d passed alarms compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ alarm_count_filter_core.f @@
hdl/acf_pkg.sv
hdl/acf_step.sv
hdl/alarm_count_filter_core.sv
tb/acf_checker.sv
tb/tb_alarm_count_filter_core.sv
